/* src/range_sum_count_defines.svh */
// Assertion macros used by the bound checker file rsc_checker.sv.
`ifndef RANGE_SUM_COUNT_DEFINES_SVH
`define RANGE_SUM_COUNT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define RSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rsc_pkg.sv */
package rsc_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int VALUE_W   = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int PREFIX_W  = VALUE_W + IDX_W;
  localparam int DIFF_W    = PREFIX_W + 1;
  localparam int COUNT_W   = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 1'b1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } rsc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] range_count;
    logic               overflow;
  } rsc_out_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } rsc_hit_t;

endpackage

/* src/rsc_match.sv */
module rsc_match (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 op_valid,
  input  logic signed [rsc_pkg::PREFIX_W-1:0]  prefix,
  input  logic signed [rsc_pkg::PREFIX_W-1:0]  operand,
  input  logic signed [rsc_pkg::VALUE_W-1:0]   win_lo,
  input  logic signed [rsc_pkg::VALUE_W-1:0]   win_hi,
  output rsc_pkg::rsc_hit_t                    res,
  output logic                                 busy
);

  logic signed [rsc_pkg::DIFF_W-1:0] diff_r;
  logic                              diff_v_r;
  logic                              hit_r;
  logic                              hit_v_r;
  logic signed [rsc_pkg::DIFF_W-1:0] lo_x;
  logic signed [rsc_pkg::DIFF_W-1:0] hi_x;

  assign lo_x = rsc_pkg::DIFF_W'(win_lo);
  assign hi_x = rsc_pkg::DIFF_W'(win_hi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_v_r <= 1'b0;
      hit_v_r  <= 1'b0;
    end else begin
      diff_v_r <= op_valid;
      hit_v_r  <= diff_v_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= rsc_pkg::DIFF_W'(prefix) - rsc_pkg::DIFF_W'(operand);
    hit_r  <= (diff_r >= lo_x) && (diff_r <= hi_x);
  end

  assign res.valid = hit_v_r;
  assign res.hit   = hit_r;
  assign busy      = diff_v_r | hit_v_r;

endmodule

/* src/range_sum_count.sv */
// Each request compares its new prefix with zero and the n prefixes already held (at most 1023).
// The shared window compare unit visits one stored prefix per cycle through a single read port.
// A dropped request skips the scan, and a last request passes through the finish state to load the result.
// Requests are accepted while a result waits; only a following last request stalls until then.
// Synchronous active-low reset clears the window registers, the sums and the result valid.
module range_sum_count (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rsc_pkg::rsc_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rsc_pkg::rsc_out_t                     out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rsc_pkg::VALUE_W-1:0]           cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                             state_r;
  logic signed [rsc_pkg::VALUE_W-1:0]     win_lo_r;
  logic signed [rsc_pkg::VALUE_W-1:0]     win_hi_r;
  logic signed [rsc_pkg::PREFIX_W-1:0]    run_r;
  logic signed [rsc_pkg::PREFIX_W-1:0]    np_r;
  logic signed [rsc_pkg::PREFIX_W-1:0]    np_nxt;
  logic [rsc_pkg::COUNT_W-1:0]            total_r;
  logic [rsc_pkg::CNT_W-1:0]              items_r;
  logic [rsc_pkg::CNT_W-1:0]              n_r;
  logic [rsc_pkg::CNT_W-1:0]              rd_cnt_r;
  logic                                   drop_r;
  logic                                   last_r;
  logic                                   zero_v_r;
  logic                                   rd_v_r;
  logic signed [rsc_pkg::PREFIX_W-1:0]    rd_q_r;
  logic                                   out_valid_r;
  rsc_pkg::rsc_out_t                      out_data_r;

  logic signed [rsc_pkg::PREFIX_W-1:0]    mem [rsc_pkg::MAX_ITEMS];

  logic                                   in_acc;
  logic                                   room;
  logic                                   issue;
  logic                                   out_free;
  logic                                   scan_done;
  logic                                   m_busy;
  logic signed [rsc_pkg::PREFIX_W-1:0]    m_operand;
  rsc_pkg::rsc_hit_t                      m_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_acc    = in_valid && in_ready;
  assign room      = (items_r < rsc_pkg::CNT_W'(rsc_pkg::MAX_ITEMS));
  assign np_nxt    = run_r + rsc_pkg::PREFIX_W'(in_data.value);
  assign issue     = (state_r == ST_SCAN) && (rd_cnt_r != n_r);
  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = (state_r == ST_SCAN) && (rd_cnt_r == n_r) && !zero_v_r && !rd_v_r
                     && !m_busy;

  // The empty range prefix (zero) enters the compare unit first, then the stored prefixes.
  assign m_operand = zero_v_r ? '0 : rd_q_r;

  rsc_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (zero_v_r | rd_v_r),
    .prefix   (np_r),
    .operand  (m_operand),
    .win_lo   (win_lo_r),
    .win_hi   (win_hi_r),
    .res      (m_res),
    .busy     (m_busy)
  );

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[items_r[rsc_pkg::IDX_W-1:0]] <= np_nxt;
    end
    rd_q_r <= mem[rd_cnt_r[rsc_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_data_r.range_count <= total_r;
      out_data_r.overflow    <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_lo_r    <= '0;
      win_hi_r    <= '0;
      run_r       <= '0;
      np_r        <= '0;
      total_r     <= '0;
      items_r     <= '0;
      n_r         <= '0;
      rd_cnt_r    <= '0;
      drop_r      <= 1'b0;
      last_r      <= 1'b0;
      zero_v_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsc_pkg::REG_WINDOW_LOW:  win_lo_r <= cfg_data;
          rsc_pkg::REG_WINDOW_HIGH: win_hi_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      zero_v_r <= in_acc && room;
      rd_v_r   <= issue;
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end

      if (m_res.valid && m_res.hit && (total_r != rsc_pkg::COUNT_MAX)) begin
        total_r <= total_r + 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            last_r <= in_data.last;
            if (room) begin
              np_r     <= np_nxt;
              run_r    <= np_nxt;
              n_r      <= items_r;
              items_r  <= items_r + 1'b1;
              rd_cnt_r <= '0;
              state_r  <= ST_SCAN;
            end else begin
              drop_r <= 1'b1;
              if (in_data.last) begin
                state_r <= ST_FIN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_r <= last_r ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            run_r       <= '0;
            total_r     <= '0;
            items_r     <= '0;
            drop_r      <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/rsc_checker.sv */
`include "range_sum_count_defines.svh"

module rsc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input rsc_pkg::rsc_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input rsc_pkg::rsc_out_t out_data
);

  // Result: low in reset, held if stalled, raised only once a last request is counted.
  `RSC_ASSERT_ALWAYS(a_out_reset, !rst_n |=> !out_valid, "result valid after reset")
  `RSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped while stalled")
  `RSC_ASSERT(a_no_early_result, in_valid && in_ready && !in_data.last |=> !$rose(out_valid), "result without final request")
  `RSC_ASSERT(a_result_while_busy, $rose(out_valid) |-> $past(!in_ready), "result loaded while accepting requests")

endmodule

bind range_sum_count rsc_checker u_rsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/range_sum_count_checker.sv */
`timescale 1ns / 1ps

module range_sum_count_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  rsc_pkg::rsc_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  rsc_pkg::rsc_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsc_pkg::VALUE_W-1:0]   cfg_data,
  output int                            mismatches,
  output int                            awaited,
  output int                            results_seen
);
  import rsc_pkg::*;

  logic signed [VALUE_W-1:0]  window_lo;
  logic signed [VALUE_W-1:0]  window_hi;
  logic signed [PREFIX_W-1:0] prefix_hist [MAX_ITEMS];
  logic signed [PREFIX_W-1:0] prefix_acc;
  logic [COUNT_W-1:0]         range_tally;
  int                         held_items;
  logic                       items_dropped;
  rsc_out_t                   pending_counts [$];

  function automatic bit in_window(input logic signed [DIFF_W-1:0] diff);
    return (diff >= window_lo) && (diff <= window_hi);
  endfunction

  function automatic void clear_sequence();
    prefix_acc    = '0;
    range_tally   = '0;
    held_items    = 0;
    items_dropped = 1'b0;
  endfunction

  function automatic bit predict_range_count(input rsc_in_t req, output rsc_out_t res);
    logic signed [PREFIX_W-1:0] next_prefix;
    logic signed [DIFF_W-1:0]   diff;
    int                         hits;
    int                         sum_tally;
    res = '0;
    if (held_items < MAX_ITEMS) begin
      next_prefix = prefix_acc + $signed(req.value);
      diff = next_prefix;
      hits = in_window(diff);
      for (int i = 0; i < held_items; i++) begin
        diff = next_prefix - prefix_hist[i];
        hits += in_window(diff);
      end
      sum_tally = int'(range_tally) + hits;
      range_tally = (sum_tally > COUNT_MAX) ? COUNT_MAX : sum_tally[COUNT_W-1:0];
      prefix_hist[held_items] = next_prefix;
      prefix_acc = next_prefix;
      held_items++;
    end else begin
      items_dropped = 1'b1;
    end
    if (!req.last) return 1'b0;
    res.range_count = range_tally;
    res.overflow    = items_dropped;
    clear_sequence();
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    rsc_out_t want;
    rsc_out_t got;
    if (!rst_n) begin
      window_lo    = '0;
      window_hi    = '0;
      mismatches   = 0;
      results_seen = 0;
      clear_sequence();
      pending_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_LOW) begin
          window_lo = cfg_data;
        end else if (cfg_index == REG_WINDOW_HIGH) begin
          window_hi = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        got = out_data;
        results_seen++;
        if (pending_counts.size() == 0) begin
          mismatches++;
          $error("Unexpected result: range_count %0d, overflow %0b", got.range_count,
                 got.overflow);
        end else begin
          want = pending_counts.pop_front();
          if (got.range_count !== want.range_count) begin
            mismatches++;
            $error("range_count: expected %0d, actual %0d", want.range_count,
                   got.range_count);
          end
          if (got.overflow !== want.overflow) begin
            mismatches++;
            $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (predict_range_count(in_data, want)) pending_counts.push_back(want);
      end
    end
    awaited = pending_counts.size();
  end

endmodule

/* test/range_sum_count_tb.sv */
`timescale 1ns / 1ps

module range_sum_count_tb;
  import rsc_pkg::*;

  localparam int TIMEOUT_CYCLES  = 3_000_000;
  localparam int RANDOM_REQUESTS = 580;
  localparam int STALL_CYCLES    = 4000;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef enum int {STYLE_SMALL, STYLE_WIDE, STYLE_EXTREME} value_style_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  rsc_in_t              in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_LOW;
  logic [VALUE_W-1:0]   cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  rsc_out_t             out_data;

  int   mismatches;
  int   awaited;
  int   results_seen;
  int   cycle_count    = 0;
  int   requests_sent  = 0;
  int   settings_used  = 0;
  logic calm           = 1'b0;
  logic hold_armed     = 1'b0;

  range_sum_count dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  range_sum_count_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .results_seen (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic offer_request(input logic signed [VALUE_W-1:0] value, input logic last);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{value: value, last: last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic set_window(input logic signed [VALUE_W-1:0] lo,
                            input logic signed [VALUE_W-1:0] hi);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW_LOW;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_WINDOW_HIGH;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_sequence(input int length, input value_style_e style);
    logic signed [VALUE_W-1:0] v;
    for (int k = 0; k < length; k++) begin
      case (style)
        STYLE_SMALL: v = $urandom_range(0, 40) - 20;
        STYLE_WIDE:  v = $urandom();
        default: begin
          case ($urandom_range(0, 4))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = 0;
            3: v = -1;
            default: v = 1;
          endcase
        end
      endcase
      offer_request(v, k == length - 1);
    end
  endtask

  task automatic pick_window();
    logic signed [VALUE_W-1:0] lo;
    case ($urandom_range(0, 5))
      0, 1: begin
        lo = $urandom_range(0, 40) - 30;
        set_window(lo, lo + $urandom_range(0, 40));
      end
      2: begin
        lo = $urandom_range(0, 40) - 20;
        set_window(lo, lo - $urandom_range(1, 20));
      end
      3: set_window(VALUE_MIN, VALUE_MAX);
      4: set_window(0, VALUE_MAX);
      default: set_window($urandom(), $urandom());
    endcase
  endtask

  initial begin : stimulus
    int start_count;
    int seq_index;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests, starting from the window left by reset.
    offer_request(0, 1'b0);
    offer_request(0, 1'b0);
    offer_request(5, 1'b1);

    set_window(VALUE_MIN, VALUE_MAX);
    offer_request(VALUE_MAX, 1'b0);
    offer_request(VALUE_MAX, 1'b0);
    offer_request(VALUE_MIN, 1'b0);
    offer_request(VALUE_MIN, 1'b0);
    offer_request(-1, 1'b1);

    set_window(5, -5);
    offer_request(1, 1'b0);
    offer_request(-1, 1'b0);
    offer_request(0, 1'b0);
    offer_request(3, 1'b1);

    set_window(VALUE_MIN, VALUE_MIN);
    offer_request(VALUE_MIN, 1'b1);
    offer_request(VALUE_MIN, 1'b0);
    offer_request(0, 1'b1);

    set_window(VALUE_MAX, VALUE_MAX);
    offer_request(VALUE_MAX, 1'b0);
    offer_request(VALUE_MIN, 1'b0);
    offer_request(VALUE_MAX, 1'b1);

    set_window(-2, 2);
    offer_request(1, 1'b1);
    offer_request(0, 1'b1);

    // Fill the prefix store to capacity, then drop two requests, the last one flagged.
    set_window(VALUE_MIN, VALUE_MAX);
    for (int k = 0; k < MAX_ITEMS + 2; k++) begin
      offer_request($urandom_range(0, 2) - 1, k == MAX_ITEMS + 1);
    end

    start_count = requests_sent;
    seq_index   = 0;
    while (requests_sent - start_count < RANDOM_REQUESTS) begin
      if (seq_index % 6 == 0) pick_window();
      if (seq_index == 0) hold_armed = 1'b1;
      calm = (seq_index >= 20) && (seq_index < 32);
      run_sequence(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                               : $urandom_range(1, 16),
                   value_style_e'($urandom_range(0, 2)));
      seq_index++;
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (MAX_ITEMS + 40) @(negedge clk);
    $display("tb: %0d requests sent under %0d window settings, %0d results checked",
             requests_sent, settings_used, results_seen);
    $display("tb: covered store overflow, empty and extreme windows and a %0d-cycle stall",
             STALL_CYCLES);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
